@@ design/slcp_pkg.sv @@
// shared constants, types and codes of the sampled lcp array builder
`default_nettype none
package slcp_pkg;

    localparam int MAX_LEN = 4096;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = ADDR_W + 1;
    localparam int SYM_W   = 8;
    localparam int LCP_W   = 12;
    localparam int WB_W    = 5;
    localparam int CFG_W   = 13;
    localparam logic [LCP_W-1:0] LCP_CAP = {LCP_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_COMPUTE = 2'd1,
        CMD_READ    = 2'd2
    } cmd_e;

    typedef enum logic [0:0] {
        REG_SAMPLE_STEP = 1'b0,
        REG_TEXT_LENGTH = 1'b1
    } reg_idx_e;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] position;
        logic [SYM_W-1:0]  symbol;
        logic [ADDR_W-1:0] suffix_start;
    } item_t;

    typedef struct packed {
        logic [LCP_W-1:0] sampled_lcp;
        logic [LEN_W-1:0] sampled_count;
        logic [WB_W-1:0]  width_bits;
        logic             index_ok;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] sfx_raddr;
        logic [ADDR_W-1:0] rank_raddr;
        logic              rank_we;
        logic [ADDR_W-1:0] rank_waddr;
        logic [ADDR_W-1:0] rank_wdata;
        logic [ADDR_W-1:0] lcp_raddr;
        logic              lcp_we;
        logic [ADDR_W-1:0] lcp_waddr;
        logic [LCP_W-1:0]  lcp_wdata;
        logic [ADDR_W-1:0] txt_raddr_a;
        logic [ADDR_W-1:0] txt_raddr_b;
        logic [ADDR_W-1:0] mark_raddr;
        logic              mark_we;
        logic [ADDR_W-1:0] mark_waddr;
        logic              mark_wdata;
    } mem_req_t;

    typedef enum logic [3:0] {
        E_IDLE,
        E_RANK,
        E_K_ISSUE,
        E_K_RANK,
        E_K_SFX,
        E_K_CMP_ISSUE,
        E_K_CMP,
        E_SAMPLE,
        E_FIN
    } eng_state_e;

endpackage
`default_nettype wire

@@ design/slcp_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module slcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ design/slcp_engine.sv @@
// compute sequencer: rank build, kasai lcp pass and sampling pass
`default_nettype none
module slcp_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [slcp_pkg::CFG_W-1:0]  sample_step,
    input  logic [slcp_pkg::CFG_W-1:0]  text_length,
    input  logic [slcp_pkg::ADDR_W-1:0] sfx_rdata,
    input  logic [slcp_pkg::ADDR_W-1:0] rank_rdata,
    input  logic [slcp_pkg::LCP_W-1:0]  lcp_rdata,
    input  logic [slcp_pkg::SYM_W-1:0]  txt_rdata_a,
    input  logic [slcp_pkg::SYM_W-1:0]  txt_rdata_b,
    input  logic                        mark_rdata,
    output slcp_pkg::mem_req_t          req,
    output logic                        busy,
    output logic                        fin,
    output logic [slcp_pkg::LEN_W-1:0]  kept_count,
    output logic [slcp_pkg::WB_W-1:0]   width_bits
);
    import slcp_pkg::*;

    localparam logic [LEN_W-1:0] MAX_N = LEN_W'(MAX_LEN);

    eng_state_e state_reg, state_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [CFG_W-1:0]  step_reg, step_next;
    logic [LEN_W-1:0]  ctr_reg, ctr_next;
    logic [CFG_W-1:0]  mod_reg, mod_next;
    logic              pv_reg, pv_next;
    logic [ADDR_W-1:0] pi_reg, pi_next;
    logic [LEN_W-1:0]  i_reg, i_next;
    logic [LEN_W-1:0]  l_reg, l_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0] p_reg, p_next;
    logic              bv_reg, bv_next;
    logic              cv_reg, cv_next;
    logic [LCP_W-1:0]  clcp_reg, clcp_next;
    logic [LEN_W-1:0]  j_reg, j_next;
    logic [LCP_W-1:0]  run_reg, run_next;
    logic [LCP_W-1:0]  maxv_reg, maxv_next;
    logic              prev_reg, prev_next;
    logic              first_reg, first_next;
    logic [LEN_W-1:0]  kept_reg, kept_next;
    logic [WB_W-1:0]   width_reg, width_next;

    logic [LEN_W:0]    sum_a, sum_b;
    logic              finish;
    logic [LCP_W-1:0]  new_run;
    logic [WB_W-1:0]   hb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            kept_reg  <= '0;
            width_reg <= '0;
            pv_reg    <= 1'b0;
            bv_reg    <= 1'b0;
            cv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kept_reg  <= kept_next;
            width_reg <= width_next;
            pv_reg    <= pv_next;
            bv_reg    <= bv_next;
            cv_reg    <= cv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        step_reg  <= step_next;
        ctr_reg   <= ctr_next;
        mod_reg   <= mod_next;
        pi_reg    <= pi_next;
        i_reg     <= i_next;
        l_reg     <= l_next;
        k_reg     <= k_next;
        p_reg     <= p_next;
        clcp_reg  <= clcp_next;
        j_reg     <= j_next;
        run_reg   <= run_next;
        maxv_reg  <= maxv_next;
        prev_reg  <= prev_next;
        first_reg <= first_next;
    end

    // highest set bit of the largest kept lcp
    always_comb
    begin
        hb = '0;
        for (int b = 0; b < LCP_W; b++)
        begin
            if (maxv_reg[b])
            begin
                hb = WB_W'(b);
            end
        end
    end

    assign sum_a   = {1'b0, i_reg} + {1'b0, l_reg};
    assign sum_b   = {2'b0, p_reg} + {1'b0, l_reg};
    assign new_run = (prev_reg || (clcp_reg < run_reg)) ? clcp_reg : run_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        step_next  = step_reg;
        ctr_next   = ctr_reg;
        mod_next   = mod_reg;
        pv_next    = pv_reg;
        pi_next    = pi_reg;
        i_next     = i_reg;
        l_next     = l_reg;
        k_next     = k_reg;
        p_next     = p_reg;
        bv_next    = bv_reg;
        cv_next    = cv_reg;
        clcp_next  = clcp_reg;
        j_next     = j_reg;
        run_next   = run_reg;
        maxv_next  = maxv_reg;
        prev_next  = prev_reg;
        first_next = first_reg;
        kept_next  = kept_reg;
        width_next = width_reg;
        finish     = 1'b0;
        req        = '0;

        case (state_reg)
            E_IDLE:
            begin
                if (go)
                begin
                    n_next     = (text_length > MAX_N) ? MAX_N : text_length;
                    step_next  = (sample_step == '0) ? CFG_W'(1) : sample_step;
                    ctr_next   = '0;
                    mod_next   = '0;
                    pv_next    = 1'b0;
                    state_next = E_RANK;
                end
            end
            E_RANK:
            begin
                // inverse suffix array; also mark every position that is a multiple of step
                if (pv_reg && ({1'b0, pi_reg} < n_reg) && ({1'b0, sfx_rdata} < n_reg))
                begin
                    req.rank_we    = 1'b1;
                    req.rank_waddr = sfx_rdata;
                    req.rank_wdata = pi_reg;
                end
                if (ctr_reg < MAX_N)
                begin
                    req.sfx_raddr  = ctr_reg[ADDR_W-1:0];
                    req.mark_we    = 1'b1;
                    req.mark_waddr = ctr_reg[ADDR_W-1:0];
                    req.mark_wdata = (mod_reg == '0);
                    pv_next        = 1'b1;
                    pi_next        = ctr_reg[ADDR_W-1:0];
                    ctr_next       = ctr_reg + LEN_W'(1);
                    mod_next       = (mod_reg == step_reg - CFG_W'(1)) ? '0
                                                                      : mod_reg + CFG_W'(1);
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        i_next     = '0;
                        l_next     = '0;
                        state_next = E_K_ISSUE;
                    end
                end
            end
            E_K_ISSUE:
            begin
                if (i_reg < n_reg)
                begin
                    req.rank_raddr = i_reg[ADDR_W-1:0];
                    state_next     = E_K_RANK;
                end
                else
                begin
                    ctr_next   = '0;
                    bv_next    = 1'b0;
                    cv_next    = 1'b0;
                    j_next     = '0;
                    maxv_next  = '0;
                    run_next   = '0;
                    prev_next  = 1'b1;
                    first_next = 1'b0;
                    state_next = E_SAMPLE;
                end
            end
            E_K_RANK:
            begin
                if ({1'b0, rank_rdata} >= n_reg)
                begin
                    i_next     = i_reg + LEN_W'(1);
                    state_next = E_K_ISSUE;
                end
                else if (rank_rdata == '0)
                begin
                    req.lcp_we    = 1'b1;
                    req.lcp_waddr = '0;
                    req.lcp_wdata = '0;
                    i_next        = i_reg + LEN_W'(1);
                    state_next    = E_K_ISSUE;
                end
                else
                begin
                    req.sfx_raddr = rank_rdata - ADDR_W'(1);
                    k_next        = rank_rdata;
                    state_next    = E_K_SFX;
                end
            end
            E_K_SFX:
            begin
                p_next     = sfx_rdata;
                state_next = E_K_CMP_ISSUE;
            end
            E_K_CMP_ISSUE:
            begin
                if ((sum_a < {1'b0, n_reg}) && (sum_b < {1'b0, n_reg}))
                begin
                    req.txt_raddr_a = sum_a[ADDR_W-1:0];
                    req.txt_raddr_b = sum_b[ADDR_W-1:0];
                    state_next      = E_K_CMP;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            E_K_CMP:
            begin
                if (txt_rdata_a == txt_rdata_b)
                begin
                    l_next     = l_reg + LEN_W'(1);
                    state_next = E_K_CMP_ISSUE;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            E_SAMPLE:
            begin
                // stage a: suffix and lcp reads
                if (ctr_reg < n_reg)
                begin
                    req.sfx_raddr = ctr_reg[ADDR_W-1:0];
                    req.lcp_raddr = ctr_reg[ADDR_W-1:0];
                    bv_next       = 1'b1;
                    ctr_next      = ctr_reg + LEN_W'(1);
                end
                else
                begin
                    bv_next = 1'b0;
                end
                // stage b: mark lookup by suffix start
                req.mark_raddr = sfx_rdata;
                cv_next        = bv_reg;
                clcp_next      = lcp_rdata;
                // stage c: range minimum and compaction
                if (cv_reg)
                begin
                    if (mark_rdata)
                    begin
                        if (clcp_reg > maxv_reg)
                        begin
                            maxv_next = clcp_reg;
                        end
                        run_next      = new_run;
                        req.lcp_we    = 1'b1;
                        req.lcp_waddr = j_reg[ADDR_W-1:0];
                        req.lcp_wdata = new_run;
                        j_next        = j_reg + LEN_W'(1);
                        prev_next     = 1'b1;
                        first_next    = 1'b1;
                    end
                    else if (first_reg)
                    begin
                        run_next  = new_run;
                        prev_next = 1'b0;
                    end
                end
                if ((ctr_reg >= n_reg) && !bv_reg && !cv_reg)
                begin
                    state_next = E_FIN;
                end
            end
            E_FIN:
            begin
                kept_next  = j_reg;
                width_next = (maxv_reg == '0) ? WB_W'(3) : hb + WB_W'(4);
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase

        if (finish)
        begin
            req.lcp_we    = 1'b1;
            req.lcp_waddr = k_reg;
            req.lcp_wdata = (l_reg > {1'b0, LCP_CAP}) ? LCP_CAP : l_reg[LCP_W-1:0];
            l_next        = (l_reg == '0) ? '0 : l_reg - LEN_W'(1);
            i_next        = i_reg + LEN_W'(1);
            state_next    = E_K_ISSUE;
        end
    end

    assign busy       = (state_reg != E_IDLE);
    assign fin        = (state_reg == E_FIN);
    assign kept_count = kept_reg;
    assign width_bits = width_reg;
endmodule
`default_nettype wire

@@ design/sampled_lcp_array_builder_top.sv @@
// top level of the sampled lcp array builder: config port, command front end, stores
`default_nettype none
//
// channel   direction  handshake                    payload
// command   in         start & !busy                item (cmd, position, symbol, suffix_start)
// result    out        done, one cycle, no stall    result (sampled_lcp, sampled_count,
//                                                   width_bits, index_ok)
// config    in         psel & penable & pwrite      pwdata at paddr 0 / 4
//
// load and read may be issued back to back; the result
// shows up in the cycle after the transaction is accepted
// compute runs in the engine: a rank/mark sweep over all 4096 positions; a kasai pass
// that writes lcp 0 for the suffix with rank 0, skips a suffix with no rank, and for
// the others compares symbol pairs until a mismatch or the end of the text, then
// closes the suffix; a sampling pass over the first n suffix array entries (n the
// clipped length), then a closing state; busy is high meanwhile
// the pace of compute is set by the single read port of each store
// reset clears the control state, kept count and width; stores are not cleared
//
module sampled_lcp_array_builder_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  slcp_pkg::item_t              item,
    output logic                         done,
    output slcp_pkg::result_t            result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import slcp_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] step_reg, step_next;
    logic [CFG_W-1:0] len_reg, len_next;
    logic             cfg_wr;

    // command front end
    logic             accept;
    logic             go;
    logic             done_reg, done_next;
    logic             rd_ok_reg, rd_ok_next;
    logic             load_we;

    // engine
    mem_req_t          req;
    logic              eng_busy;
    logic              eng_fin;
    logic [LEN_W-1:0]  kept_count;
    logic [WB_W-1:0]   width_bits;

    // store read data
    logic [ADDR_W-1:0] sfx_rdata;
    logic [ADDR_W-1:0] rank_rdata;
    logic [LCP_W-1:0]  lcp_rdata;
    logic [SYM_W-1:0]  txt_rdata_a;
    logic [SYM_W-1:0]  txt_rdata_b;
    logic              mark_rdata;
    logic [ADDR_W-1:0] lcp_raddr;

    // apb register file, writes only land while idle by contract; the block itself does not enforce it
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        step_next = step_reg;
        len_next  = len_reg;
        if (cfg_wr)
        begin
            case (reg_idx_e'(paddr[2]))
                REG_SAMPLE_STEP: step_next = pwdata[CFG_W-1:0];
                REG_TEXT_LENGTH: len_next  = pwdata[CFG_W-1:0];
                default:         step_next = step_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_e'(paddr[2]))
            REG_SAMPLE_STEP: prdata = {{(32-CFG_W){1'b0}}, step_reg};
            REG_TEXT_LENGTH: prdata = {{(32-CFG_W){1'b0}}, len_reg};
            default:         prdata = '0;
        endcase
    end

    // transaction accepted only when the engine is idle
    assign accept  = start && !eng_busy;
    assign go      = accept && (item.cmd == CMD_COMPUTE);
    assign load_we = accept && (item.cmd == CMD_LOAD);

    always_comb
    begin
        done_next  = eng_fin || (accept && (item.cmd != CMD_COMPUTE));
        rd_ok_next = accept && (item.cmd == CMD_READ)
                     && ({1'b0, item.position} < kept_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= CFG_W'(1);
            len_reg   <= CFG_W'(1);
            done_reg  <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            len_reg   <= len_next;
            done_reg  <= done_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    // host reads of the lcp store go straight to the ram; data returns next cycle
    assign lcp_raddr = eng_busy ? req.lcp_raddr : item.position;

    slcp_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .sample_step (step_reg),
        .text_length (len_reg),
        .sfx_rdata   (sfx_rdata),
        .rank_rdata  (rank_rdata),
        .lcp_rdata   (lcp_rdata),
        .txt_rdata_a (txt_rdata_a),
        .txt_rdata_b (txt_rdata_b),
        .mark_rdata  (mark_rdata),
        .req         (req),
        .busy        (eng_busy),
        .fin         (eng_fin),
        .kept_count  (kept_count),
        .width_bits  (width_bits)
    );

    // text store, duplicated for two compare reads per cycle
    slcp_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_text_a (
        .clk   (clk),
        .we    (load_we),
        .waddr (item.position),
        .wdata (item.symbol),
        .raddr (req.txt_raddr_a),
        .rdata (txt_rdata_a)
    );

    slcp_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_text_b (
        .clk   (clk),
        .we    (load_we),
        .waddr (item.position),
        .wdata (item.symbol),
        .raddr (req.txt_raddr_b),
        .rdata (txt_rdata_b)
    );

    slcp_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LEN)) u_suffix (
        .clk   (clk),
        .we    (load_we),
        .waddr (item.position),
        .wdata (item.suffix_start),
        .raddr (req.sfx_raddr),
        .rdata (sfx_rdata)
    );

    slcp_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LEN)) u_rank (
        .clk   (clk),
        .we    (req.rank_we),
        .waddr (req.rank_waddr),
        .wdata (req.rank_wdata),
        .raddr (req.rank_raddr),
        .rdata (rank_rdata)
    );

    slcp_ram #(.WIDTH(LCP_W), .DEPTH(MAX_LEN)) u_lcp (
        .clk   (clk),
        .we    (req.lcp_we),
        .waddr (req.lcp_waddr),
        .wdata (req.lcp_wdata),
        .raddr (lcp_raddr),
        .rdata (lcp_rdata)
    );

    // one flag per start position: multiple of the sampling step
    slcp_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_mark (
        .clk   (clk),
        .we    (req.mark_we),
        .waddr (req.mark_waddr),
        .wdata (req.mark_wdata),
        .raddr (req.mark_raddr),
        .rdata (mark_rdata)
    );

    // result transaction
    assign busy                 = eng_busy;
    assign done                 = done_reg;
    assign result.sampled_lcp   = rd_ok_reg ? lcp_rdata : '0;
    assign result.sampled_count = kept_count;
    assign result.width_bits    = width_bits;
    assign result.index_ok      = rd_ok_reg;
endmodule
`default_nettype wire
